@@ src/hkmt_pkg.sv @@
// Shared types, constants and the scancode decode table for the key matrix translator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package hkmt_pkg;

    localparam logic [2:0] RSHIFT_ROW = 3'd6;
    localparam logic [2:0] RSHIFT_COL = 3'd4;
    localparam logic       REQ_SCAN   = 1'b0;
    localparam logic       REQ_DIRECT = 1'b1;

    // One decoded key event as it travels from front to back.
    typedef struct packed {
        logic       hit;
        logic       stick;
        logic       shift;
        logic       key_up;
        logic [2:0] row;
        logic [2:0] col;
        logic [4:0] mask;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic cmd_t km(input logic [2:0] r, input logic [2:0] c, input logic s);
        cmd_t e;
        e        = '0;
        e.hit    = 1'b1;
        e.shift  = s;
        e.row    = r;
        e.col    = c;
        return e;
    endfunction

    function automatic cmd_t js(input logic [4:0] m);
        cmd_t e;
        e       = '0;
        e.hit   = 1'b1;
        e.stick = 1'b1;
        e.mask  = m;
        return e;
    endfunction

    // Host usage code to matrix position or joystick lines; key_up is filled in later.
    function automatic cmd_t decode_scan(input logic [7:0] sc);
        cmd_t e;
        e = '0;
        case (sc)
            8'd4:   e = km(3'd1, 3'd2, 1'b0);
            8'd5:   e = km(3'd3, 3'd4, 1'b0);
            8'd6:   e = km(3'd2, 3'd4, 1'b0);
            8'd7:   e = km(3'd2, 3'd2, 1'b0);
            8'd8:   e = km(3'd1, 3'd6, 1'b0);
            8'd9:   e = km(3'd2, 3'd5, 1'b0);
            8'd10:  e = km(3'd3, 3'd2, 1'b0);
            8'd11:  e = km(3'd3, 3'd5, 1'b0);
            8'd12:  e = km(3'd4, 3'd1, 1'b0);
            8'd13:  e = km(3'd4, 3'd2, 1'b0);
            8'd14:  e = km(3'd4, 3'd5, 1'b0);
            8'd15:  e = km(3'd5, 3'd2, 1'b0);
            8'd16:  e = km(3'd4, 3'd4, 1'b0);
            8'd17:  e = km(3'd4, 3'd7, 1'b0);
            8'd18:  e = km(3'd4, 3'd6, 1'b0);
            8'd19:  e = km(3'd5, 3'd1, 1'b0);
            8'd20:  e = km(3'd7, 3'd6, 1'b0);
            8'd21:  e = km(3'd2, 3'd1, 1'b0);
            8'd22:  e = km(3'd1, 3'd5, 1'b0);
            8'd23:  e = km(3'd2, 3'd6, 1'b0);
            8'd24:  e = km(3'd3, 3'd6, 1'b0);
            8'd25:  e = km(3'd3, 3'd7, 1'b0);
            8'd26:  e = km(3'd1, 3'd1, 1'b0);
            8'd27:  e = km(3'd2, 3'd7, 1'b0);
            8'd28:  e = km(3'd3, 3'd1, 1'b0);
            8'd29:  e = km(3'd1, 3'd4, 1'b0);
            8'd30:  e = km(3'd7, 3'd0, 1'b0);
            8'd31:  e = km(3'd7, 3'd3, 1'b0);
            8'd32:  e = km(3'd1, 3'd0, 1'b0);
            8'd33:  e = km(3'd1, 3'd3, 1'b0);
            8'd34:  e = km(3'd2, 3'd0, 1'b0);
            8'd35:  e = km(3'd2, 3'd3, 1'b0);
            8'd36:  e = km(3'd3, 3'd0, 1'b0);
            8'd37:  e = km(3'd3, 3'd3, 1'b0);
            8'd38:  e = km(3'd4, 3'd0, 1'b0);
            8'd39:  e = km(3'd4, 3'd3, 1'b0);
            8'd40:  e = km(3'd0, 3'd1, 1'b0);
            8'd41:  e = km(3'd7, 3'd7, 1'b0);
            8'd42:  e = km(3'd0, 3'd0, 1'b0);
            8'd43:  e = km(3'd7, 3'd2, 1'b0);
            8'd44:  e = km(3'd7, 3'd4, 1'b0);
            8'd45:  e = km(3'd5, 3'd0, 1'b0);
            8'd46:  e = km(3'd5, 3'd3, 1'b0);
            8'd47:  e = km(3'd5, 3'd6, 1'b0);
            8'd48:  e = km(3'd6, 3'd1, 1'b0);
            8'd49:  e = km(3'd6, 3'd6, 1'b0);
            8'd51:  e = km(3'd5, 3'd5, 1'b0);
            8'd52:  e = km(3'd6, 3'd2, 1'b0);
            8'd53:  e = km(3'd7, 3'd1, 1'b0);
            8'd54:  e = km(3'd5, 3'd7, 1'b0);
            8'd55:  e = km(3'd5, 3'd4, 1'b0);
            8'd56:  e = km(3'd6, 3'd7, 1'b0);
            8'd58:  e = km(3'd0, 3'd4, 1'b0);
            8'd59:  e = km(3'd0, 3'd4, 1'b1);
            8'd60:  e = km(3'd0, 3'd5, 1'b0);
            8'd61:  e = km(3'd0, 3'd5, 1'b1);
            8'd62:  e = km(3'd0, 3'd6, 1'b0);
            8'd63:  e = km(3'd0, 3'd6, 1'b1);
            8'd64:  e = km(3'd0, 3'd3, 1'b0);
            8'd65:  e = km(3'd0, 3'd3, 1'b1);
            8'd73:  e = km(3'd0, 3'd0, 1'b1);
            8'd74:  e = km(3'd6, 3'd3, 1'b0);
            8'd75:  e = km(3'd6, 3'd6, 1'b0);
            8'd76:  e = km(3'd0, 3'd0, 1'b0);
            8'd77:  e = km(3'd6, 3'd0, 1'b0);
            8'd78:  e = km(3'd6, 3'd5, 1'b0);
            8'd79:  e = km(3'd0, 3'd2, 1'b0);
            8'd80:  e = km(3'd0, 3'd2, 1'b1);
            8'd81:  e = km(3'd0, 3'd7, 1'b0);
            8'd82:  e = km(3'd0, 3'd7, 1'b1);
            8'd89:  e = js(5'h06);
            8'd90:  e = js(5'h02);
            8'd91:  e = js(5'h0a);
            8'd92:  e = js(5'h04);
            8'd93:  e = js(5'h10);
            8'd94:  e = js(5'h08);
            8'd95:  e = js(5'h05);
            8'd96:  e = js(5'h01);
            8'd97:  e = js(5'h09);
            8'd98:  e = js(5'h10);
            8'd224: e = km(3'd7, 3'd2, 1'b0);
            8'd225: e = km(3'd1, 3'd7, 1'b0);
            8'd226: e = km(3'd7, 3'd5, 1'b0);
            8'd228: e = km(3'd7, 3'd2, 1'b0);
            8'd229: e = km(3'd6, 3'd4, 1'b0);
            8'd230: e = km(3'd7, 3'd5, 1'b0);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

@@ src/host_key_to_matrix_translator_top.sv @@
// Top level of the host key to keyboard matrix translator.
// Depends on hkmt_pkg, hkmt_front, hkmt_queue and hkmt_back.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall    req_type scan_code key_code key_up
//   out      from block out_valid/out_stall  matrix_rows matrix_cols stick_lines recognized
//
// One word per cycle sustained while the output is not stalled; an accepted word passes the
// decode register, a queue slot and the matrix update into the output register, in that order.
// The rate is set by the read-modify-write of the matrix register.
// Reset releases every key and joystick line and empties the queue.
// A stalled output fills the queue first, then stalls the input.
`default_nettype none

module host_key_to_matrix_translator_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  scan_code,
    input  wire logic [5:0]  key_code,
    input  wire logic        key_up,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      matrix_rows,
    output logic [63:0]      matrix_cols,
    output logic [7:0]       stick_lines,
    output logic             recognized
);

    logic                push;
    logic                pop;
    hkmt_pkg::cmd_t      push_cmd;
    hkmt_pkg::cmd_t      head_cmd;
    hkmt_pkg::q_status_t q_status;

    hkmt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .scan_code (scan_code),
        .key_code  (key_code),
        .key_up    (key_up),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_status  (q_status)
    );

    hkmt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    hkmt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .matrix_rows (matrix_rows),
        .matrix_cols (matrix_cols),
        .stick_lines (stick_lines),
        .recognized  (recognized)
    );

endmodule

`default_nettype wire

@@ src/hkmt_front.sv @@
// Front end: accepts key words, decodes them and hands commands to the queue.
// Depends on hkmt_pkg for cmd_t, q_status_t and the decode table.
`default_nettype none

module hkmt_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [7:0]        scan_code,
    input  wire logic [5:0]        key_code,
    input  wire logic              key_up,
    output logic                   push,
    output hkmt_pkg::cmd_t         push_cmd,
    input  wire hkmt_pkg::q_status_t q_status
);

    hkmt_pkg::cmd_t cmd_reg;
    hkmt_pkg::cmd_t cmd_next;
    logic           valid_reg;
    logic           accept;

    // hold the decoded word while the queue is full
    assign in_stall = valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_status.full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        if (req_type == hkmt_pkg::REQ_DIRECT)
        begin
            cmd_next     = '0;
            cmd_next.hit = 1'b1;
            cmd_next.row = key_code[5:3];
            cmd_next.col = key_code[2:0];
        end
        else
        begin
            cmd_next = hkmt_pkg::decode_scan(scan_code);
        end
        cmd_next.key_up = key_up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ src/hkmt_queue.sv @@
// Short command queue between the decode front end and the matrix back end.
// Depends on hkmt_pkg for cmd_t and q_status_t.
`default_nettype none

module hkmt_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire hkmt_pkg::cmd_t      push_cmd,
    input  wire logic                pop,
    output hkmt_pkg::cmd_t           head_cmd,
    output hkmt_pkg::q_status_t      q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hkmt_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/hkmt_back.sv @@
// Back end: applies queued commands to the key matrix and joystick lines,
// and holds the result word in an output register. Depends on hkmt_pkg.
`default_nettype none

module hkmt_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hkmt_pkg::cmd_t      head_cmd,
    input  wire hkmt_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [63:0]              matrix_rows,
    output logic [63:0]              matrix_cols,
    output logic [7:0]               stick_lines,
    output logic                     recognized
);

    localparam logic [5:0] RSHIFT_IDX = {hkmt_pkg::RSHIFT_ROW, hkmt_pkg::RSHIFT_COL};

    logic [63:0] rows_reg;
    logic [63:0] rows_next;
    logic [7:0]  stick_reg;
    logic [7:0]  stick_next;
    logic [63:0] key_mask;
    logic [7:0]  stick_mask;
    logic        out_valid_reg;
    logic [63:0] out_rows_reg;
    logic [7:0]  out_stick_reg;
    logic        out_rec_reg;

    // advance whenever the output register is empty or being taken
    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        key_mask   = 64'd1 << {head_cmd.row, head_cmd.col};
        if (head_cmd.shift)
        begin
            key_mask = key_mask | (64'd1 << RSHIFT_IDX);
        end
        stick_mask = {3'b000, head_cmd.mask};
        rows_next  = rows_reg;
        stick_next = stick_reg;
        if (head_cmd.hit && head_cmd.stick)
        begin
            stick_next = head_cmd.key_up ? (stick_reg | stick_mask) : (stick_reg & ~stick_mask);
        end
        else if (head_cmd.hit)
        begin
            rows_next = head_cmd.key_up ? (rows_reg | key_mask) : (rows_reg & ~key_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= '1;
            stick_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rows_reg      <= rows_next;
                stick_reg     <= stick_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rows_reg  <= rows_next;
            out_stick_reg <= stick_next;
            out_rec_reg   <= head_cmd.hit;
        end
    end

    // column order is the transpose of the row order
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                matrix_cols[c*8 + r] = out_rows_reg[r*8 + c];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign matrix_rows = out_rows_reg;
    assign stick_lines = out_stick_reg;
    assign recognized  = out_rec_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the host key to keyboard matrix translator.
// Depends on hkmt_pkg and host_key_to_matrix_translator_top; predicts every output word.
`default_nettype none

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SETTLE_CYCLES = 12;

    // One line of the host scancode table
    typedef struct packed {
        logic       known;
        logic       shifted;
        logic       joy;
        logic [2:0] row;
        logic [2:0] col;
        logic [4:0] lines;
    } scan_map_t;

    // Snapshot of everything the block reports after one word
    typedef struct {
        logic [63:0] rows;
        logic [63:0] cols;
        logic [7:0]  stick;
        logic        hit;
    } matrix_snap_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  scan_code;
    logic [5:0]  key_code;
    logic        key_up;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] matrix_rows;
    logic [63:0] matrix_cols;
    logic [7:0]  stick_lines;
    logic        recognized;

    logic [7:0]   row_mirror [8];
    logic [7:0]   col_mirror [8];
    logic [7:0]   stick_mirror;
    matrix_snap_t snap_q [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    int          fail_count;
    int unsigned cycle_cnt;

    host_key_to_matrix_translator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .scan_code   (scan_code),
        .key_code    (key_code),
        .key_up      (key_up),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .matrix_rows (matrix_rows),
        .matrix_cols (matrix_cols),
        .stick_lines (stick_lines),
        .recognized  (recognized)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic scan_map_t key_at(input int r, input int c, input int s);
        scan_map_t m;
        m         = '0;
        m.known   = 1'b1;
        m.shifted = (s != 0);
        m.row     = r[2:0];
        m.col     = c[2:0];
        return m;
    endfunction

    function automatic scan_map_t joy_at(input logic [4:0] lines);
        scan_map_t m;
        m       = '0;
        m.known = 1'b1;
        m.joy   = 1'b1;
        m.lines = lines;
        return m;
    endfunction

    function automatic scan_map_t lookup_scan(input logic [7:0] sc);
        scan_map_t m;
        m = '0;
        case (sc)
            4: m = key_at(1, 2, 0);    5: m = key_at(3, 4, 0);
            6: m = key_at(2, 4, 0);    7: m = key_at(2, 2, 0);
            8: m = key_at(1, 6, 0);    9: m = key_at(2, 5, 0);
            10: m = key_at(3, 2, 0);   11: m = key_at(3, 5, 0);
            12: m = key_at(4, 1, 0);   13: m = key_at(4, 2, 0);
            14: m = key_at(4, 5, 0);   15: m = key_at(5, 2, 0);
            16: m = key_at(4, 4, 0);   17: m = key_at(4, 7, 0);
            18: m = key_at(4, 6, 0);   19: m = key_at(5, 1, 0);
            20: m = key_at(7, 6, 0);   21: m = key_at(2, 1, 0);
            22: m = key_at(1, 5, 0);   23: m = key_at(2, 6, 0);
            24: m = key_at(3, 6, 0);   25: m = key_at(3, 7, 0);
            26: m = key_at(1, 1, 0);   27: m = key_at(2, 7, 0);
            28: m = key_at(3, 1, 0);   29: m = key_at(1, 4, 0);
            30: m = key_at(7, 0, 0);   31: m = key_at(7, 3, 0);
            32: m = key_at(1, 0, 0);   33: m = key_at(1, 3, 0);
            34: m = key_at(2, 0, 0);   35: m = key_at(2, 3, 0);
            36: m = key_at(3, 0, 0);   37: m = key_at(3, 3, 0);
            38: m = key_at(4, 0, 0);   39: m = key_at(4, 3, 0);
            40: m = key_at(0, 1, 0);   41: m = key_at(7, 7, 0);
            42: m = key_at(0, 0, 0);   43: m = key_at(7, 2, 0);
            44: m = key_at(7, 4, 0);   45: m = key_at(5, 0, 0);
            46: m = key_at(5, 3, 0);   47: m = key_at(5, 6, 0);
            48: m = key_at(6, 1, 0);   49: m = key_at(6, 6, 0);
            51: m = key_at(5, 5, 0);   52: m = key_at(6, 2, 0);
            53: m = key_at(7, 1, 0);   54: m = key_at(5, 7, 0);
            55: m = key_at(5, 4, 0);   56: m = key_at(6, 7, 0);
            58: m = key_at(0, 4, 0);   59: m = key_at(0, 4, 1);
            60: m = key_at(0, 5, 0);   61: m = key_at(0, 5, 1);
            62: m = key_at(0, 6, 0);   63: m = key_at(0, 6, 1);
            64: m = key_at(0, 3, 0);   65: m = key_at(0, 3, 1);
            73: m = key_at(0, 0, 1);   74: m = key_at(6, 3, 0);
            75: m = key_at(6, 6, 0);   76: m = key_at(0, 0, 0);
            77: m = key_at(6, 0, 0);   78: m = key_at(6, 5, 0);
            79: m = key_at(0, 2, 0);   80: m = key_at(0, 2, 1);
            81: m = key_at(0, 7, 0);   82: m = key_at(0, 7, 1);
            89: m = joy_at(5'h06);     90: m = joy_at(5'h02);
            91: m = joy_at(5'h0a);     92: m = joy_at(5'h04);
            93: m = joy_at(5'h10);     94: m = joy_at(5'h08);
            95: m = joy_at(5'h05);     96: m = joy_at(5'h01);
            97: m = joy_at(5'h09);     98: m = joy_at(5'h10);
            224: m = key_at(7, 2, 0);  225: m = key_at(1, 7, 0);
            226: m = key_at(7, 5, 0);  228: m = key_at(7, 2, 0);
            229: m = key_at(6, 4, 0);  230: m = key_at(7, 5, 0);
            default: m = '0;
        endcase
        return m;
    endfunction

    task automatic toggle_key(input logic [2:0] r, input logic [2:0] c, input logic up);
        if (up)
        begin
            row_mirror[r][c] = 1'b1;
            col_mirror[c][r] = 1'b1;
        end
        else
        begin
            row_mirror[r][c] = 1'b0;
            col_mirror[c][r] = 1'b0;
        end
    endtask

    // Apply one accepted word to the mirrored matrix and queue the snapshot
    task automatic update_matrix(input logic rt, input logic [7:0] sc, input logic [5:0] kc,
                                 input logic up);
        scan_map_t    m;
        matrix_snap_t s;
        s.hit = 1'b0;
        if (rt == hkmt_pkg::REQ_DIRECT)
        begin
            toggle_key(kc[5:3], kc[2:0], up);
            s.hit = 1'b1;
        end
        else
        begin
            m = lookup_scan(sc);
            if (m.known)
            begin
                s.hit = 1'b1;
                if (m.joy)
                begin
                    if (up)
                        stick_mirror = stick_mirror | {3'b000, m.lines};
                    else
                        stick_mirror = stick_mirror & ~{3'b000, m.lines};
                end
                else
                begin
                    if (m.shifted)
                        toggle_key(hkmt_pkg::RSHIFT_ROW, hkmt_pkg::RSHIFT_COL, up);
                    toggle_key(m.row, m.col, up);
                end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            s.rows[8*i +: 8] = row_mirror[i];
            s.cols[8*i +: 8] = col_mirror[i];
        end
        s.stick = stick_mirror;
        snap_q.push_back(s);
    endtask

    task automatic send_word(input logic rt, input logic [7:0] sc, input logic [5:0] kc,
                             input logic up);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        req_type  <= rt;
        scan_code <= sc;
        key_code  <= kc;
        key_up    <= up;
        do @(posedge clk); while (in_stall);
        update_matrix(rt, sc, kc, up);
    endtask

    // Drop valid and hold the sender until every queued snapshot has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        while (snap_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        matrix_snap_t s;
        if (rst_n && out_valid && !out_stall)
        begin
            if (snap_q.size() == 0)
            begin
                $error("output word with nothing expected");
                fail_count++;
            end
            else
            begin
                s = snap_q.pop_front();
                if (matrix_rows !== s.rows)
                begin
                    $error("matrix_rows expected %h got %h", s.rows, matrix_rows);
                    fail_count++;
                end
                if (matrix_cols !== s.cols)
                begin
                    $error("matrix_cols expected %h got %h", s.cols, matrix_cols);
                    fail_count++;
                end
                if (stick_lines !== s.stick)
                begin
                    $error("stick_lines expected %h got %h", s.stick, stick_lines);
                    fail_count++;
                end
                if (recognized !== s.hit)
                begin
                    $error("recognized expected %b got %b", s.hit, recognized);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        // unknown codes report the untouched reset matrix
        send_word(hkmt_pkg::REQ_SCAN, 8'd0, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd255, 6'h3f, 1'b1);
    endtask

    task automatic test_direct_codes();
        send_word(hkmt_pkg::REQ_DIRECT, 8'hff, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_DIRECT, 8'h00, 6'd63, 1'b0);
        send_word(hkmt_pkg::REQ_DIRECT, 8'h5a, 6'd0, 1'b1);
        send_word(hkmt_pkg::REQ_DIRECT, 8'ha5, 6'd63, 1'b0);
        send_word(hkmt_pkg::REQ_DIRECT, 8'hff, 6'd63, 1'b1);
    endtask

    task automatic test_scan_keys();
        send_word(hkmt_pkg::REQ_SCAN, 8'd4, 6'h3f, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd4, 6'h00, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd4, 6'h2a, 1'b1);
        send_word(hkmt_pkg::REQ_SCAN, 8'd50, 6'h15, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd82, 6'h00, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd82, 6'h3f, 1'b1);
    endtask

    task automatic test_shifted_keys();
        // shifted entry drags right shift with it, including on release
        send_word(hkmt_pkg::REQ_SCAN, 8'd59, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd229, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd59, 6'd0, 1'b1);
        send_word(hkmt_pkg::REQ_SCAN, 8'd229, 6'd0, 1'b1);
        send_word(hkmt_pkg::REQ_SCAN, 8'd230, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_DIRECT, 8'd0, 6'h3d, 1'b1);
    endtask

    task automatic test_joystick_keys();
        send_word(hkmt_pkg::REQ_SCAN, 8'd89, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd93, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd98, 6'd0, 1'b1);
        send_word(hkmt_pkg::REQ_SCAN, 8'd89, 6'd0, 1'b1);
        send_word(hkmt_pkg::REQ_SCAN, 8'd97, 6'd0, 1'b0);
        send_word(hkmt_pkg::REQ_SCAN, 8'd97, 6'd0, 1'b1);
    endtask

    task automatic test_random_events(input int count, input int snd_pct, input int rcv_pct);
        logic [7:0] sc;
        scan_map_t  m;
        int         pick;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                // mapped scancode, key_code left as noise
                do
                begin
                    sc = 8'($urandom_range(255));
                    m  = lookup_scan(sc);
                end
                while (!m.known);
                send_word(hkmt_pkg::REQ_SCAN, sc, 6'($urandom_range(63)),
                          1'($urandom_range(1)));
            end
            else if (pick < 90)
                send_word(hkmt_pkg::REQ_DIRECT, 8'($urandom_range(255)),
                          6'($urandom_range(63)), 1'($urandom_range(1)));
            else
                send_word(hkmt_pkg::REQ_SCAN, 8'($urandom_range(255)),
                          6'($urandom_range(63)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= hkmt_pkg::REQ_SCAN;
        scan_code     <= 8'd0;
        key_code      <= 6'd0;
        key_up        <= 1'b0;
        out_stall     <= 1'b0;
        cycle_cnt     = 0;
        fail_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++)
        begin
            row_mirror[i] = 8'hff;
            col_mirror[i] = 8'hff;
        end
        stick_mirror = 8'hff;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 86;
        test_reset_state();
        test_direct_codes();
        test_scan_keys();
        test_shifted_keys();
        test_joystick_keys();
        drain_results();

        test_random_events(200, 32, 86);
        drain_results();
        test_random_events(200, 86, 32);
        drain_results();
        test_random_events(200, 0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
